/* rtl/glcd_dot_plotter_defines.svh */
// ----------------------------------------------------------------------------
// glcd_dot_plotter_defines
// assertion macros used by the dot plotter controller rtl, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef GLCD_DOT_PLOTTER_DEFINES_SVH
`define GLCD_DOT_PLOTTER_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, switched off while reset is high
`define GLCD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also during reset
`define GLCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GLCD_ASSERT(lbl, clk, rst, prop, msg)
`define GLCD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/glcd_pkg.sv */
// ----------------------------------------------------------------------------
// glcd_pkg
// types and constants of the graphic lcd dot plotter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package glcd_pkg;

   localparam int PAGES_DEF   = 8;
   localparam int COLUMNS_DEF = 128;

   // wide enough for page * columns + column at the largest parameters
   localparam int ADDR_CALC_W = 13;

   localparam logic [7:0] CMD_PAGE   = 8'hB8;
   localparam logic [7:0] CMD_COLUMN = 8'h40;

   localparam logic [1:0] CHIP_LEFT  = 2'd0;
   localparam logic [1:0] CHIP_RIGHT = 2'd1;
   localparam logic [1:0] CHIP_BOTH  = 2'd2;

   localparam logic OP_PLOT  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MERGE,
      ST_PAGE,
      ST_COLUMN,
      ST_DATA
   } state_type;

   typedef enum logic [1:0] {
      EMIT_PAGE,
      EMIT_COLUMN,
      EMIT_DATA
   } emit_sel_type;

   typedef struct packed {
      logic         capture;
      logic         clear_step;
      logic         merge;
      logic         emit;
      emit_sel_type emit_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic plot_ok;
      logic clear_last;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/glcd_ram.sv */
// ----------------------------------------------------------------------------
// glcd_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/glcd_datapath.sv */
// ----------------------------------------------------------------------------
// glcd_datapath
// frame buffer, item registers, clear counter and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glcd_datapath #(
   parameter int PAGES   = glcd_pkg::PAGES_DEF,
   parameter int COLUMNS = glcd_pkg::COLUMNS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tuser,
   input  logic [15:0]             req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic [2:0]              rsp_tuser,
   output logic                    rsp_tlast,
   input  glcd_pkg::ctrl_cmd_type  cmd,
   output glcd_pkg::dp_status_type stat
);

   import glcd_pkg::*;

   localparam int DEPTH     = PAGES * COLUMNS;
   localparam int AW        = $clog2(DEPTH);
   localparam int HALF      = COLUMNS / 2;
   localparam int ROW_LIMIT = PAGES * 8;

   logic [7:0]             in_row;
   logic [7:0]             in_column;
   logic [ADDR_CALC_W-1:0] in_addr_full;
   logic [AW-1:0]          in_addr;

   logic [7:0]    row_ff, row_in;
   logic [7:0]    column_ff, column_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [7:0]    byte_ff, byte_in;
   logic [AW-1:0] clr_idx_ff, clr_idx_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic [1:0] rsp_chip_ff, rsp_chip_in;
   logic       rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [7:0]    ram_rdata;
   logic [7:0]    merged;

   logic [8:0] col_wide;
   logic       right_chip;
   logic [1:0] chip;
   logic [7:0] page_cmd;
   logic [7:0] column_cmd;

   assign in_row       = req_tdata[7:0];
   assign in_column    = req_tdata[15:8];
   assign in_addr_full = ADDR_CALC_W'(in_row[7:3]) * ADDR_CALC_W'(COLUMNS)
                       + ADDR_CALC_W'(in_column);
   assign in_addr      = in_addr_full[AW-1:0];

   assign stat.is_clear   = (req_tuser == OP_CLEAR);
   assign stat.plot_ok    = ({1'b0, in_row} < 9'(ROW_LIMIT))
                          && ({1'b0, in_column} < 9'(COLUMNS));
   assign stat.clear_last = (clr_idx_ff == AW'(DEPTH - 1));
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   assign merged = ram_rdata | (8'd1 << row_ff[2:0]);

   // frame buffer write: sweep while clearing, read-modify-write on a plot
   always_comb begin
      ram_we    = cmd.clear_step || cmd.merge;
      ram_waddr = cmd.clear_step ? clr_idx_ff : addr_ff;
      ram_wdata = cmd.clear_step ? 8'h00 : merged;
   end

   glcd_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_frame_buffer (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (in_addr),
      .rd_data (ram_rdata)
   );

   // command bytes for the captured item
   always_comb begin
      col_wide   = {1'b0, column_ff};
      right_chip = (col_wide >= 9'(HALF));
      chip       = right_chip ? CHIP_RIGHT : CHIP_LEFT;
      page_cmd   = 8'(CMD_PAGE + {3'b000, row_ff[7:3]});
      column_cmd = 8'(9'(CMD_COLUMN) + col_wide - (right_chip ? 9'(HALF) : 9'd0));
   end

   always_comb begin
      row_in    = row_ff;
      column_in = column_ff;
      addr_in   = addr_ff;
      byte_in   = byte_ff;
      if (cmd.capture) begin
         row_in    = in_row;
         column_in = in_column;
         addr_in   = in_addr;
      end
      if (cmd.merge) begin
         byte_in = merged;
      end
   end

   always_comb begin
      clr_idx_in = clr_idx_ff;
      if (cmd.clear_step) begin
         clr_idx_in = stat.clear_last ? '0 : clr_idx_ff + AW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_chip_in  = rsp_chip_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         unique case (cmd.emit_sel)
            EMIT_PAGE: begin
               rsp_chip_in = CHIP_BOTH;
               rsp_data_in = 1'b0;
               rsp_byte_in = page_cmd;
               rsp_last_in = 1'b0;
            end
            EMIT_COLUMN: begin
               rsp_chip_in = chip;
               rsp_data_in = 1'b0;
               rsp_byte_in = column_cmd;
               rsp_last_in = 1'b0;
            end
            EMIT_DATA: begin
               rsp_chip_in = chip;
               rsp_data_in = 1'b1;
               rsp_byte_in = byte_ff;
               rsp_last_in = 1'b1;
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_tready;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      column_ff   <= column_in;
      addr_ff     <= addr_in;
      byte_ff     <= byte_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_chip_ff <= rsp_chip_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = {rsp_data_ff, rsp_chip_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/glcd_ctrl.sv */
// ----------------------------------------------------------------------------
// glcd_ctrl
// sequencer for clearing passes and the plot read-modify-write and writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "glcd_dot_plotter_defines.svh"

module glcd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  glcd_pkg::dp_status_type stat,
   output glcd_pkg::ctrl_cmd_type  cmd
);

   import glcd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.capture    = 1'b0;
      cmd.clear_step = 1'b0;
      cmd.merge      = 1'b0;
      cmd.emit       = 1'b0;
      cmd.emit_sel   = EMIT_PAGE;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (stat.is_clear) begin
                  state_in = ST_CLEAR;
               end else if (stat.plot_ok) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_MERGE;
               end
            end
         end
         ST_MERGE: begin
            // page command needs only the row, so it can leave with the merge
            cmd.merge = 1'b1;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_COLUMN;
            end else begin
               state_in = ST_PAGE;
            end
         end
         ST_PAGE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_COLUMN;
            end
         end
         ST_COLUMN: begin
            cmd.emit_sel = EMIT_COLUMN;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            cmd.emit_sel = EMIT_DATA;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `GLCD_ASSERT(a_emit_needs_room, clock, reset, cmd.emit |-> stat.out_free, "emit with full output register")
   `GLCD_ASSERT(a_clear_item_sweeps, clock, reset, (req_tvalid && req_tready && stat.is_clear) |=> (state_ff == ST_CLEAR), "clear item did not start a sweep")
   `GLCD_ASSERT(a_merge_after_accept, clock, reset, (state_ff == ST_MERGE) |-> ($past(state_ff) == ST_IDLE), "merge without an accepted plot")
   `GLCD_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (state_ff == ST_CLEAR), "reset did not start a clearing pass")

endmodule

/* rtl/glcd_dot_plotter.sv */
// ----------------------------------------------------------------------------
// glcd_dot_plotter
// a plot is accepted in idle and its byte merged into the frame buffer; the
// page, column and data writes follow in order, one write per cycle while
// rsp_tready is high, and no new item is taken until the data write is
// registered. dropped plots are taken in idle; a clear item, like the pass
// after reset, sweeps PAGES*COLUMNS entries one per cycle with req_tready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glcd_dot_plotter #(
   parameter int PAGES   = glcd_pkg::PAGES_DEF,
   parameter int COLUMNS = glcd_pkg::COLUMNS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // row [7:0], column [15:8]
   input  logic        req_tuser,   // opcode [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // bus_byte [7:0]
   output logic [2:0]  rsp_tuser,   // chip_select [1:0], is_data [2]
   output logic        rsp_tlast
);

   import glcd_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   glcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   glcd_datapath #(
      .PAGES   (PAGES),
      .COLUMNS (COLUMNS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

/* tb/tb_glcd_dot_plotter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glcd_dot_plotter
// drives plot and clear items into the dot plotter and checks every controller
// write against a shadow copy of the frame buffer, under varied idling and
// back-pressure on both sides of the block
// ----------------------------------------------------------------------------

module tb_glcd_dot_plotter;

   import glcd_pkg::*;

   localparam int FB_PAGES       = PAGES_DEF;
   localparam int FB_COLUMNS     = COLUMNS_DEF;
   localparam int FB_ROWS        = FB_PAGES * 8;
   localparam int FB_HALF        = FB_COLUMNS / 2;
   localparam int QUIET_LIMIT    = 8000;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_ITEMS   = 450;
   localparam int DRAIN_CYCLES   = 20;

   typedef struct packed {
      logic [1:0] chip;
      logic       is_data;
      logic [7:0] bus_byte;
      logic       last;
   } lcd_write_type;

   // shadow frame buffer plus the writes still owed by the block
   class frame_scoreboard;
      logic [7:0]    shadow_fb [FB_PAGES * FB_COLUMNS];
      lcd_write_type owed_writes [$];
      int            fail_count;

      function new();
         fail_count = 0;
         wipe_frame();
      endfunction

      function void wipe_frame();
         foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      endfunction

      function void note_request(logic op, logic [7:0] row, logic [7:0] col);
         int         page;
         int         addr;
         logic [1:0] chip;
         logic [7:0] col_in_chip;
         if (op == OP_CLEAR) begin
            wipe_frame();
            return;
         end
         // out of range dots are dropped silently
         if (row >= FB_ROWS || col >= FB_COLUMNS) return;
         page = row >> 3;
         addr = page * FB_COLUMNS + col;
         shadow_fb[addr] = shadow_fb[addr] | (8'h01 << row[2:0]);
         if (col < FB_HALF) begin
            chip        = CHIP_LEFT;
            col_in_chip = col;
         end else begin
            chip        = CHIP_RIGHT;
            col_in_chip = col - 8'(FB_HALF);
         end
         owed_writes.push_back('{CHIP_BOTH, 1'b0, CMD_PAGE + 8'(page), 1'b0});
         owed_writes.push_back('{chip, 1'b0, CMD_COLUMN + col_in_chip, 1'b0});
         owed_writes.push_back('{chip, 1'b1, shadow_fb[addr], 1'b1});
      endfunction

      function void compare_field(string field, int want, logic [7:0] got);
         if (^got === 1'bx || got != want[7:0]) begin
            $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, field,
                     want, got);
            fail_count++;
         end
      endfunction

      function void check_write(lcd_write_type got);
         lcd_write_type want;
         if (owed_writes.size() == 0) begin
            $display("%0t: unexpected write, expected none, actual chip %0d data %0d byte %0h last %0d",
                     $time, got.chip, got.is_data, got.bus_byte, got.last);
            fail_count++;
            return;
         end
         want = owed_writes.pop_front();
         compare_field("chip_select", want.chip, 8'(got.chip));
         compare_field("is_data", want.is_data, 8'(got.is_data));
         compare_field("bus_byte", want.bus_byte, got.bus_byte);
         compare_field("last", want.last, 8'(got.last));
      endfunction

      function int pending();
         return owed_writes.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   frame_scoreboard sb;
   int              send_idle_pct;
   int              rsp_stall_pct;
   bit              hold_request;

   glcd_dot_plotter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // offer one item, idling first at the current rate, and wait for it to go in
   task automatic send_item(logic op, logic [7:0] row, logic [7:0] col);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {col, row};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, row, col);
   endtask

   task automatic send_random_item();
      int         pick;
      logic [7:0] row;
      logic [7:0] col;
      pick = $urandom_range(99);
      if (pick < 3) begin
         send_item(OP_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (pick < 13) begin
         if ($urandom_range(1)) begin
            row = 8'($urandom_range(255, FB_ROWS));
            col = 8'($urandom_range(255));
         end else begin
            row = 8'($urandom_range(FB_ROWS - 1));
            col = 8'($urandom_range(255, FB_COLUMNS));
         end
         send_item(OP_PLOT, row, col);
      end else begin
         row = 8'($urandom_range(FB_ROWS - 1));
         // a few hot columns so bytes build up several bits
         if ($urandom_range(1))
            col = $urandom_range(1) ? 8'($urandom_range(3))
                                    : 8'($urandom_range(FB_COLUMNS - 1, FB_COLUMNS - 4));
         else
            col = 8'($urandom_range(FB_COLUMNS - 1));
         send_item(OP_PLOT, row, col);
      end
   endtask

   // receiver: random stalls, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_write('{rsp_tuser[1:0], rsp_tuser[2], rsp_tdata, rsp_tlast});
   end

   // ends the run when neither side moves an item for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int idle_set [4];
      int stall_set [4];
      sb            = new();
      idle_set      = '{0, 76, 0, 34};
      stall_set     = '{0, 0, 76, 34};
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = OP_PLOT;
      rsp_tready    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // corners, both chips, bit build-up, drops and clears
      send_item(OP_PLOT, 8'd0, 8'd0);
      send_item(OP_PLOT, 8'd63, 8'd127);
      send_item(OP_PLOT, 8'd7, 8'd63);
      send_item(OP_PLOT, 8'd8, 8'd64);
      send_item(OP_PLOT, 8'd1, 8'd0);
      send_item(OP_PLOT, 8'd2, 8'd0);
      send_item(OP_PLOT, 8'd62, 8'd127);
      send_item(OP_PLOT, 8'd64, 8'd0);
      send_item(OP_PLOT, 8'd0, 8'd128);
      send_item(OP_PLOT, 8'd255, 8'd255);
      send_item(OP_PLOT, 8'd63, 8'd255);
      send_item(OP_PLOT, 8'd128, 8'd127);
      send_item(OP_CLEAR, 8'd255, 8'd255);
      send_item(OP_PLOT, 8'd0, 8'd0);
      send_item(OP_PLOT, 8'd56, 8'd64);
      send_item(OP_CLEAR, 8'd0, 8'd0);
      send_item(OP_PLOT, 8'd31, 8'd100);
      send_item(OP_PLOT, 8'd32, 8'd65);

      // long receiver hold-off while dots keep coming
      hold_request = 1'b1;
      repeat (20) send_item(OP_PLOT, 8'($urandom_range(FB_ROWS - 1)),
                            8'($urandom_range(FB_COLUMNS - 1)));

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_set[phase];
         rsp_stall_pct = stall_set[phase];
         repeat (RANDOM_ITEMS / 4) send_random_item();
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/glcd_pkg.sv
rtl/glcd_ram.sv
rtl/glcd_datapath.sv
rtl/glcd_ctrl.sv
rtl/glcd_dot_plotter.sv
tb/tb_glcd_dot_plotter.sv
